[hdl/ced_pkg.sv]
// ---------------------------------------------------------------------------
// ced_pkg: shared types, constants and arithmetic for the edge detector
// Window types, geometry, direction codes and the per-stage pixel maths.
// ---------------------------------------------------------------------------
`default_nettype none

package ced_pkg;

  localparam int MAX_LINE_WIDTH   = 2048;
  localparam int MAX_FRAME_HEIGHT = 2048;
  localparam int LINE_AW          = $clog2(MAX_LINE_WIDTH);
  localparam int COORD_W          = 11;
  localparam int SIZE_W           = 12;
  localparam int MIN_SIZE         = 5;
  localparam int FILL_CAP         = MAX_LINE_WIDTH + 2;
  localparam int FILL_W           = $clog2(FILL_CAP + 1);
  localparam int CMP_W            = SIZE_W + 2;
  // tan(22.5) and tan(67.5) with eight fractional bits
  localparam int TAN_LO           = 106;
  localparam int TAN_HI           = 618;
  localparam int PROD_W           = 21;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH,
    REG_FRAME_HEIGHT,
    REG_HIGH_THR,
    REG_LOW_THR
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_0,
    DIR_45,
    DIR_90,
    DIR_135
  } dir_t;

  typedef logic [7:0]         pix_t;
  typedef pix_t [8:0]         win_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]  size_t;

  typedef struct packed {
    size_t w;
    size_t h;
  } geom_t;

  typedef struct packed {
    logic   vld;
    coord_t row;
    coord_t col;
  } pos_t;

  typedef struct packed {
    pix_t mag;
    dir_t dir;
  } grad_t;

  // Saturate a programmed size to its legal range
  function automatic size_t clamp_size(input size_t v, input size_t max_v);
    size_t r;
    r = v;
    if (v < size_t'(MIN_SIZE)) r = size_t'(MIN_SIZE);
    if (v > max_v) r = max_v;
    return r;
  endfunction

  // Position one line and one pixel earlier in raster order
  function automatic pos_t back_pos(input coord_t row, input coord_t col, input geom_t g);
    pos_t            p;
    logic [SIZE_W:0] rr;
    p.vld = 1'b1;
    if (col != '0) begin
      p.col = col - coord_t'(1);
      rr    = {2'b00, row} + {1'b0, g.h} - (SIZE_W+1)'(1);
    end else begin
      p.col = coord_t'(g.w - size_t'(1));
      rr    = {2'b00, row} + {1'b0, g.h} - (SIZE_W+1)'(2);
    end
    if (rr >= {1'b0, g.h}) rr = rr - {1'b0, g.h};
    p.row = coord_t'(rr);
    return p;
  endfunction

  function automatic logic is_ring(input pos_t p, input geom_t g);
    return (p.row == '0) || (p.col == '0) ||
           ({1'b0, p.row} >= g.h - size_t'(1)) || ({1'b0, p.col} >= g.w - size_t'(1));
  endfunction

  // 1 2 1 / 2 4 2 / 1 2 1 smoothing, divided by 16
  function automatic pix_t gauss(input win_t wn);
    logic [11:0] s;
    s = 12'(wn[0]) + (12'(wn[1]) << 1) + 12'(wn[2])
      + (12'(wn[3]) << 1) + (12'(wn[4]) << 2) + (12'(wn[5]) << 1)
      + 12'(wn[6]) + (12'(wn[7]) << 1) + 12'(wn[8]);
    return s[11:4];
  endfunction

  // Centred Sobel: magnitude |gx|+|gy| saturated, direction by tangent compares
  function automatic grad_t sobel(input win_t wn);
    grad_t              gr;
    logic [11:0]        px, nx, py, ny;
    logic signed [11:0] gx, gy;
    logic [10:0]        ax, ay;
    logic [11:0]        m;
    logic [PROD_W-1:0]  lhs, r_lo, r_hi;
    px = 12'(wn[2]) + (12'(wn[5]) << 1) + 12'(wn[8]);
    nx = 12'(wn[0]) + (12'(wn[3]) << 1) + 12'(wn[6]);
    py = 12'(wn[6]) + (12'(wn[7]) << 1) + 12'(wn[8]);
    ny = 12'(wn[0]) + (12'(wn[1]) << 1) + 12'(wn[2]);
    gx = signed'(px - nx);
    gy = signed'(py - ny);
    ax = gx[11] ? 11'(-gx) : 11'(gx);
    ay = gy[11] ? 11'(-gy) : 11'(gy);
    m  = {1'b0, ax} + {1'b0, ay};
    gr.mag = (m > 12'd255) ? 8'hFF : m[7:0];
    lhs  = PROD_W'(ay) << 8;
    r_lo = PROD_W'(ax) * PROD_W'(TAN_LO);
    r_hi = PROD_W'(ax) * PROD_W'(TAN_HI);
    if (lhs <= r_lo)     gr.dir = DIR_0;
    else if (lhs > r_hi) gr.dir = DIR_90;
    else if ((gx > 12'sd0) == (gy > 12'sd0)) gr.dir = DIR_45;
    else                 gr.dir = DIR_135;
    return gr;
  endfunction

  // Keep the centre only if no neighbour along the gradient beats it
  function automatic pix_t nms(input win_t wn, input dir_t d);
    pix_t a, b;
    case (d)
      DIR_0:   begin a = wn[3]; b = wn[5]; end
      DIR_45:  begin a = wn[0]; b = wn[8]; end
      DIR_90:  begin a = wn[1]; b = wn[7]; end
      default: begin a = wn[2]; b = wn[6]; end
    endcase
    return ((wn[4] < a) || (wn[4] < b)) ? 8'd0 : wn[4];
  endfunction

  function automatic logic hyst(input win_t wn, input pix_t hi, input pix_t lo);
    logic hi_seen;
    hi_seen = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (wn[i] > hi) hi_seen = 1'b1;
    end
    if (wn[4] < lo) return 1'b0;
    if (wn[4] > hi) return 1'b1;
    return hi_seen;
  endfunction

endpackage

`default_nettype wire

[hdl/canny_edge_stream.sv]
// ---------------------------------------------------------------------------
// canny_edge_stream: streaming 3x3 edge detector
// Gaussian, Sobel, thinning and hysteresis over raster grey pixels.
// ---------------------------------------------------------------------------
// Usage
//   Input beat: one grey pixel in raster order; in_frame_start marks the first
//   pixel of a frame and clears the row and column counters.
//   Result beat: edge decision with its row and column; out_frame_end is set
//   on the bottom-right pixel. The frame ring always reads as background.
//   Configuration: cfg_index selects line width, frame height, high or low
//   threshold; cfg_ready is always high. Write only while the block is idle.
//   Throughput: one pixel per clock while not stalled. Four chained window
//   stages, each one register deep, plus the result register.
//   Latency: a decision belongs to the pixel 4*W+4 positions back and is
//   presented once the beat that releases it has passed the window stages
//   and the result register; the first decision after reset needs
//   4*(W+1)+1 pixels. The tail of a frame drains as the next frame streams in.
//   Reset clears counters, windows and fill counts; the line stores hold
//   garbage until written and need no clearing pass.
//   Stall: while a result waits under out_stall the whole pipeline holds and
//   in_stall is raised.
// ---------------------------------------------------------------------------
`default_nettype none

module canny_edge_stream (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              in_pixel,
  input  wire logic                    in_frame_start,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_edge_res,
  output logic [ced_pkg::COORD_W-1:0]  out_row,
  output logic [ced_pkg::COORD_W-1:0]  out_col,
  output logic                         out_frame_end,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [ced_pkg::SIZE_W-1:0] cfg_data
);

  import ced_pkg::*;

  size_t  lw_r, fh_r;
  pix_t   hi_r, lo_r;
  geom_t  geom;
  logic   adv, acc;
  coord_t row_r, col_r, r_cur, c_cur, row_nxt, col_nxt;
  pos_t   it0, it1, it2, it3, ce0, ce1, ce2, ce3;
  win_t   w0, w1, w2, w3;
  pix_t   g_val, thin_val;
  grad_t  grad, grad_val;
  dir_t   dir_r, nd, dq_eff, dfwd_d_r, dd_r;
  logic [1:0] dq;
  logic   dfwd_r;
  logic   out_valid_r, edge_r, fe_r;
  coord_t orow_r, ocol_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= size_t'(640);
      fh_r <= size_t'(480);
      hi_r <= 8'd150;
      lo_r <= 8'd70;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINE_WIDTH:   lw_r <= cfg_data;
        REG_FRAME_HEIGHT: fh_r <= cfg_data;
        REG_HIGH_THR:     hi_r <= cfg_data[7:0];
        REG_LOW_THR:      lo_r <= cfg_data[7:0];
        default:          lw_r <= lw_r;
      endcase
    end
  end

  assign geom.w = clamp_size(lw_r, size_t'(MAX_LINE_WIDTH));
  assign geom.h = clamp_size(fh_r, size_t'(MAX_FRAME_HEIGHT));

  // Advance the whole pipeline unless a result is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // Raster counters
  assign r_cur = in_frame_start ? '0 : row_r;
  assign c_cur = in_frame_start ? '0 : col_r;

  always_comb begin
    row_nxt = r_cur;
    col_nxt = c_cur + coord_t'(1);
    if ({1'b0, c_cur} + size_t'(1) >= geom.w) begin
      col_nxt = '0;
      row_nxt = ({1'b0, r_cur} + size_t'(1) >= geom.h) ? '0 : r_cur + coord_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Smoothing
  ced_window u_gauss (
    .clk(clk), .rst_n(rst_n), .adv(adv), .geom(geom),
    .in_vld(acc), .in_val(in_pixel), .in_row(r_cur), .in_col(c_cur),
    .item(it0), .centre(ce0), .win(w0)
  );

  assign g_val = is_ring(ce0, geom) ? w0[4] : gauss(w0);

  // Gradient
  ced_window u_sobel (
    .clk(clk), .rst_n(rst_n), .adv(adv), .geom(geom),
    .in_vld(ce0.vld), .in_val(g_val), .in_row(ce0.row), .in_col(ce0.col),
    .item(it1), .centre(ce1), .win(w1)
  );

  assign grad     = sobel(w1);
  assign grad_val = is_ring(ce1, geom) ? '{mag: 8'd0, dir: DIR_0} : grad;

  // Thinning; the direction trails the magnitude by one line and one pixel
  ced_window u_nms (
    .clk(clk), .rst_n(rst_n), .adv(adv), .geom(geom),
    .in_vld(ce1.vld), .in_val(grad_val.mag), .in_row(ce1.row), .in_col(ce1.col),
    .item(it2), .centre(ce2), .win(w2)
  );

  always_ff @(posedge clk) begin
    if (adv) dir_r <= grad_val.dir;
  end

  ced_ram #(.WIDTH(2), .DEPTH(MAX_LINE_WIDTH)) u_dir_line (
    .clk(clk), .rd_en(adv), .rd_addr(ce1.col[LINE_AW-1:0]), .rd_data(dq),
    .wr_en(adv && it2.vld), .wr_addr(it2.col[LINE_AW-1:0]), .wr_data(dir_r)
  );

  assign dq_eff = dfwd_r ? dfwd_d_r : dir_t'(dq);
  assign nd     = dd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfwd_r <= 1'b0;
      dd_r   <= DIR_0;
    end else if (adv) begin
      dfwd_r <= it2.vld && (it2.col[LINE_AW-1:0] == ce1.col[LINE_AW-1:0]);
      if (it2.vld) dd_r <= dq_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) dfwd_d_r <= dir_r;
  end

  assign thin_val = is_ring(ce2, geom) ? 8'd0 : nms(w2, nd);

  // Hysteresis
  ced_window u_hyst (
    .clk(clk), .rst_n(rst_n), .adv(adv), .geom(geom),
    .in_vld(ce2.vld), .in_val(thin_val), .in_row(ce2.row), .in_col(ce2.col),
    .item(it3), .centre(ce3), .win(w3)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ce3.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      edge_r <= !is_ring(ce3, geom) && hyst(w3, hi_r, lo_r) && it3.vld;
      orow_r <= ce3.row;
      ocol_r <= ce3.col;
      fe_r   <= ({1'b0, ce3.row} == geom.h - size_t'(1)) &&
                ({1'b0, ce3.col} == geom.w - size_t'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_edge_res  = edge_r;
  assign out_row       = orow_r;
  assign out_col       = ocol_r;
  assign out_frame_end = fe_r;

endmodule

`default_nettype wire

[hdl/ced_ram.sv]
// ---------------------------------------------------------------------------
// ced_ram: simple dual-port RAM
// One write port, one read port with registered read data (read-first).
// ---------------------------------------------------------------------------
`default_nettype none

module ced_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

endmodule

`default_nettype wire

[hdl/ced_window.sv]
// ---------------------------------------------------------------------------
// ced_window: one 3x3 window stage
// Two line stores, the window registers, a fill count and the position of
// the window centre. Advances one beat whenever adv is high.
// ---------------------------------------------------------------------------
`default_nettype none

module ced_window (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire ced_pkg::geom_t  geom,
  input  wire logic            in_vld,
  input  wire ced_pkg::pix_t   in_val,
  input  wire ced_pkg::coord_t in_row,
  input  wire ced_pkg::coord_t in_col,
  output ced_pkg::pos_t        item,
  output ced_pkg::pos_t        centre,
  output ced_pkg::win_t        win
);

  import ced_pkg::*;

  logic        vld_r;
  pix_t        val_r;
  coord_t      row_r, col_r;
  pix_t        a_q, b_q, a_eff, b_eff;
  logic        fwd_r;
  pix_t        fwd_a_r, fwd_b_r;
  win_t        win_r, win_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic        ready;
  logic        push;
  pos_t        bp;

  assign push = adv && vld_r;

  // Previous line and the one before it
  ced_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_line_a (
    .clk(clk), .rd_en(adv), .rd_addr(in_col[LINE_AW-1:0]), .rd_data(a_q),
    .wr_en(push), .wr_addr(col_r[LINE_AW-1:0]), .wr_data(val_r)
  );

  ced_ram #(.WIDTH(8), .DEPTH(MAX_LINE_WIDTH)) u_line_b (
    .clk(clk), .rd_en(adv), .rd_addr(in_col[LINE_AW-1:0]), .rd_data(b_q),
    .wr_en(push), .wr_addr(col_r[LINE_AW-1:0]), .wr_data(a_eff)
  );

  // Forward a write that lands on the column being read in the same beat
  assign a_eff = fwd_r ? fwd_a_r : a_q;
  assign b_eff = fwd_r ? fwd_b_r : b_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (adv) begin
      fwd_r <= vld_r && (col_r[LINE_AW-1:0] == in_col[LINE_AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_a_r <= val_r;
      fwd_b_r <= a_eff;
    end
  end

  // Hold the incoming beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= in_val;
      row_r <= in_row;
      col_r <= in_col;
    end
  end

  // Shift a new column into the window
  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[2] = b_eff;
    win_nxt[5] = a_eff;
    win_nxt[8] = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (push) begin
      win_r <= win_nxt;
    end
  end

  // Count beats until the window first covers a full neighbourhood
  assign cnt_nxt = (cnt_r < FILL_W'(FILL_CAP)) ? cnt_r + FILL_W'(1) : cnt_r;
  assign ready   = CMP_W'(cnt_nxt) >= (CMP_W'(geom.w) + CMP_W'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign bp         = back_pos(row_r, col_r, geom);
  assign centre.vld = vld_r && ready;
  assign centre.row = bp.row;
  assign centre.col = bp.col;
  assign item.vld   = vld_r;
  assign item.row   = row_r;
  assign item.col   = col_r;
  assign win        = win_nxt;

endmodule

`default_nettype wire
